// File: hw/rtl/hid_keyboard_report_builder_top_macros.svh
// Assertion macros shared by the keyboard report builder RTL.
// Each macro expects clk_i and rst_ni to exist in the enclosing module.
`ifndef HID_KEYBOARD_REPORT_BUILDER_TOP_MACROS_SVH
`define HID_KEYBOARD_REPORT_BUILDER_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define HKRB_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define HKRB_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/hkrb_pkg.sv
// Package for the keyboard report builder: codes, types and the key decode.
// No dependencies; used by every module of the block.
package hkrb_pkg;

  localparam int unsigned KEY_SLOT_COUNT = 6;
  localparam int unsigned SHOWN_SLOTS    = 6;

  // Request function codes.
  localparam logic [1:0] FUNC_PRESS       = 2'd0;
  localparam logic [1:0] FUNC_RELEASE     = 2'd1;
  localparam logic [1:0] FUNC_RELEASE_ALL = 2'd2;
  localparam logic [1:0] FUNC_POLL        = 2'd3;

  // Key code ranges and usage bases.
  localparam logic [7:0] CODE_MOD_LO   = 8'h80;
  localparam logic [7:0] CODE_MOD_HI   = 8'h87;
  localparam logic [7:0] CODE_SPEC_LO  = 8'hB0;
  localparam logic [7:0] CODE_SPEC_HI  = 8'hB3;
  localparam logic [7:0] CODE_CAPS     = 8'hC1;
  localparam logic [7:0] CODE_FKEY_LO  = 8'hC2;
  localparam logic [7:0] CODE_FKEY_HI  = 8'hCD;
  localparam logic [7:0] CODE_NAV_LO   = 8'hD1;
  localparam logic [7:0] CODE_NAV_HI   = 8'hD6;
  localparam logic [7:0] CODE_ARROW_LO = 8'hD7;
  localparam logic [7:0] CODE_ARROW_HI = 8'hDA;

  localparam logic [7:0] USAGE_SPEC_BASE  = 8'h28;
  localparam logic [7:0] USAGE_CAPS       = 8'h39;
  localparam logic [7:0] USAGE_FKEY_BASE  = 8'h3A;
  localparam logic [7:0] USAGE_NAV_BASE   = 8'h49;
  localparam logic [7:0] USAGE_ARROW_BASE = 8'h4F;

  localparam logic [7:0] LEFT_SHIFT = 8'h02;

  typedef logic [KEY_SLOT_COUNT-1:0][7:0] key_slots_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;
    logic decode;
    logic execute;
  } dp_cmd_t;

  // Outcome of the key decode.
  typedef struct packed {
    logic       is_mod;
    logic [2:0] mod_idx;
    logic       shift;
    logic [7:0] usage;
  } key_dec_t;

  // ASCII to usage; bit 7 marks a character typed with shift.
  localparam logic [7:0] ASCII_ROM [128] = '{
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h2a,8'h2b,8'h28,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h29,8'h00,8'h00,8'h00,8'h00,
    8'h2c,8'h9e,8'hb4,8'ha0,8'ha1,8'ha2,8'ha4,8'h34,
    8'ha6,8'ha7,8'ha5,8'hae,8'h36,8'h2d,8'h37,8'h38,
    8'h27,8'h1e,8'h1f,8'h20,8'h21,8'h22,8'h23,8'h24,
    8'h25,8'h26,8'hb3,8'h33,8'hb6,8'h2e,8'hb7,8'hb8,
    8'h9f,8'h84,8'h85,8'h86,8'h87,8'h88,8'h89,8'h8a,
    8'h8b,8'h8c,8'h8d,8'h8e,8'h8f,8'h90,8'h91,8'h92,
    8'h93,8'h94,8'h95,8'h96,8'h97,8'h98,8'h99,8'h9a,
    8'h9b,8'h9c,8'h9d,8'h2f,8'h31,8'h30,8'ha3,8'had,
    8'h35,8'h04,8'h05,8'h06,8'h07,8'h08,8'h09,8'h0a,
    8'h0b,8'h0c,8'h0d,8'h0e,8'h0f,8'h10,8'h11,8'h12,
    8'h13,8'h14,8'h15,8'h16,8'h17,8'h18,8'h19,8'h1a,
    8'h1b,8'h1c,8'h1d,8'haf,8'hb1,8'hb0,8'hb5,8'h00
  };

  // Maps a key code to a modifier bit or a usage; usage 0 means unmapped.
  function automatic key_dec_t decode_key(logic [7:0] code);
    key_dec_t   d;
    logic [7:0] v;
    d = '0;
    v = ASCII_ROM[code[6:0]];
    if (code >= CODE_MOD_LO && code <= CODE_MOD_HI) begin
      d.is_mod  = 1'b1;
      d.mod_idx = code[2:0];
    end else if (code >= CODE_ARROW_LO && code <= CODE_ARROW_HI) begin
      d.usage = USAGE_ARROW_BASE + (code - CODE_ARROW_LO);
    end else if (code >= CODE_SPEC_LO && code <= CODE_SPEC_HI) begin
      d.usage = USAGE_SPEC_BASE + (code - CODE_SPEC_LO);
    end else if (code == CODE_CAPS) begin
      d.usage = USAGE_CAPS;
    end else if (code >= CODE_FKEY_LO && code <= CODE_FKEY_HI) begin
      d.usage = USAGE_FKEY_BASE + (code - CODE_FKEY_LO);
    end else if (code >= CODE_NAV_LO && code <= CODE_NAV_HI) begin
      d.usage = USAGE_NAV_BASE + (code - CODE_NAV_LO);
    end else if (!code[7]) begin
      d.shift = v[7];
      d.usage = {1'b0, v[6:0]};
    end
    return d;
  endfunction

endpackage

// File: hw/rtl/hkrb_ctrl.sv
// Sequencer of the keyboard report builder: load, decode, execute.
// Depends on hkrb_pkg and the assertion macro header.
`include "hid_keyboard_report_builder_top_macros.svh"

module hkrb_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  output hkrb_pkg::dp_cmd_t cmd_o
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_DECODE = 2'd1;
  localparam logic [1:0] ST_EXEC   = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd_o.decode = 1'b1;
        state_d      = ST_EXEC;
      end
      ST_EXEC: begin
        cmd_o.execute = 1'b1;
        state_d       = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

  `HKRB_ASSERT_NEXT(a_accept_goes_busy, start_i && !busy_o, busy_o && cmd_o.decode,
                    "accepted request did not enter decode")
  `HKRB_ASSERT_NEXT(a_exec_returns_idle, cmd_o.execute, !busy_o,
                    "controller did not return to idle after execute")

endmodule

// File: hw/rtl/hkrb_datapath.sv
// Datapath of the keyboard report builder: request latch, decode register,
// report state and result registers. Depends on hkrb_pkg and the macro header.
`include "hid_keyboard_report_builder_top_macros.svh"

module hkrb_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  hkrb_pkg::dp_cmd_t    cmd_i,
  input  logic [1:0]           func_i,
  input  logic [7:0]           key_code_i,
  output logic                 done_o,
  output logic                 accepted_o,
  output logic                 report_valid_o,
  output logic [7:0]           modifier_o,
  output hkrb_pkg::key_slots_t slots_o
);

  localparam int unsigned SlotIdxW =
    (hkrb_pkg::KEY_SLOT_COUNT > 1) ? $clog2(hkrb_pkg::KEY_SLOT_COUNT) : 1;

  logic [1:0]           func_q;
  logic [7:0]           code_q;
  hkrb_pkg::key_dec_t   dec_q;

  logic [7:0]           mod_q, mod_d;
  hkrb_pkg::key_slots_t slots_q, slots_d;
  logic                 dirty_q, dirty_d;
  logic                 done_q, acc_q, acc_d, valid_q, valid_d;

  logic [hkrb_pkg::KEY_SLOT_COUNT-1:0] match, free;
  logic                                any_match, any_free;
  logic [SlotIdxW-1:0]                 match_idx, free_idx;
  logic [7:0]                          mod_bit;

  // Request latch and decode register; payload only, no reset needed.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= func_i;
      code_q <= key_code_i;
    end
    if (cmd_i.decode) begin
      dec_q <= hkrb_pkg::decode_key(code_q);
    end
  end

  // Slot compares run in parallel; the lowest hit wins.
  always_comb begin
    any_match = 1'b0;
    any_free  = 1'b0;
    match_idx = '0;
    free_idx  = '0;
    for (int i = hkrb_pkg::KEY_SLOT_COUNT - 1; i >= 0; i--) begin
      match[i] = (slots_q[i] == dec_q.usage);
      free[i]  = (slots_q[i] == 8'h00);
      if (match[i]) begin
        any_match = 1'b1;
        match_idx = SlotIdxW'(i);
      end
      if (free[i]) begin
        any_free = 1'b1;
        free_idx = SlotIdxW'(i);
      end
    end
  end

  assign mod_bit = 8'h01 << dec_q.mod_idx;

  always_comb begin
    mod_d   = mod_q;
    slots_d = slots_q;
    dirty_d = dirty_q;
    acc_d   = 1'b0;
    valid_d = 1'b0;
    case (func_q)
      hkrb_pkg::FUNC_PRESS: begin
        if (dec_q.is_mod) begin
          mod_d   = mod_q | mod_bit;
          dirty_d = 1'b1;
          acc_d   = 1'b1;
        end else if (dec_q.usage != 8'h00) begin
          if (dec_q.shift) begin
            mod_d = mod_q | hkrb_pkg::LEFT_SHIFT;
          end
          if (any_match) begin
            acc_d = 1'b1;
          end else if (any_free) begin
            slots_d[free_idx] = dec_q.usage;
            dirty_d           = 1'b1;
            acc_d             = 1'b1;
          end
        end
      end
      hkrb_pkg::FUNC_RELEASE: begin
        if (dec_q.is_mod) begin
          mod_d   = mod_q & ~mod_bit;
          dirty_d = 1'b1;
          acc_d   = 1'b1;
        end else if (dec_q.usage != 8'h00) begin
          if (dec_q.shift) begin
            mod_d = mod_q & ~hkrb_pkg::LEFT_SHIFT;
          end
          if (any_match) begin
            slots_d[match_idx] = 8'h00;
            dirty_d            = 1'b1;
            acc_d              = 1'b1;
          end
        end
      end
      hkrb_pkg::FUNC_RELEASE_ALL: begin
        mod_d   = '0;
        slots_d = '0;
        dirty_d = 1'b1;
        acc_d   = 1'b1;
      end
      default: begin
        if (dirty_q) begin
          valid_d = 1'b1;
          acc_d   = 1'b1;
          dirty_d = 1'b0;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q   <= '0;
      slots_q <= '0;
      dirty_q <= 1'b0;
      done_q  <= 1'b0;
      acc_q   <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      done_q <= cmd_i.execute;
      if (cmd_i.execute) begin
        mod_q   <= mod_d;
        slots_q <= slots_d;
        dirty_q <= dirty_d;
        acc_q   <= acc_d;
        valid_q <= valid_d;
      end
    end
  end

  assign done_o         = done_q;
  assign accepted_o     = acc_q;
  assign report_valid_o = valid_q;
  assign modifier_o     = mod_q;
  assign slots_o        = slots_q;

  `HKRB_ASSERT_NEXT(a_done_follows_exec, cmd_i.execute, done_q,
                    "result strobe missing after execute")
  `HKRB_ASSERT_IMP(a_valid_needs_accept, done_q && valid_q, acc_q && !dirty_q,
                   "valid report without acceptance or with dirty flag left set")

endmodule

// File: hw/rtl/hid_keyboard_report_builder_top.sv
// Top level of the keyboard report builder.
// Depends on hkrb_pkg, hkrb_ctrl and hkrb_datapath.
//
// The block keeps a boot keyboard report: a modifier byte and six key slots,
// plus a dirty flag. A request (func_i, key_code_i) is taken at a rising edge
// where start_i is high and busy_o is low; it presses or releases a key,
// releases all keys, or polls for the report. Each request passes through
// these steps in order: it is latched, the key decode (range tests and the
// ASCII table) is registered, and all slots are compared in parallel and
// the report is updated. The result is then shown for exactly one cycle with
// done_o high; in that same cycle busy_o is already low, so the next request
// may be issued. No new request is taken while one is still in progress.
// The receiver cannot stall: a result must be captured while done_o is high.
// accepted_o says whether the request took effect; report_valid_o is set only
// for a poll that found the report changed since the last poll, and that
// poll clears the change flag. The modifier and slot outputs always show the
// report as it stands after the request, and hold until the next result.
module hid_keyboard_report_builder_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  logic [1:0] func_i,
  input  logic [7:0] key_code_i,
  output logic       done_o,
  output logic       accepted_o,
  output logic       report_valid_o,
  output logic [7:0] modifier_bits_o,
  output logic [7:0] key_slot_0_o,
  output logic [7:0] key_slot_1_o,
  output logic [7:0] key_slot_2_o,
  output logic [7:0] key_slot_3_o,
  output logic [7:0] key_slot_4_o,
  output logic [7:0] key_slot_5_o
);

  hkrb_pkg::dp_cmd_t    cmd;
  hkrb_pkg::key_slots_t slots;
  logic [hkrb_pkg::SHOWN_SLOTS-1:0][7:0] shown;

  hkrb_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .cmd_o   (cmd)
  );

  hkrb_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .func_i         (func_i),
    .key_code_i     (key_code_i),
    .done_o         (done_o),
    .accepted_o     (accepted_o),
    .report_valid_o (report_valid_o),
    .modifier_o     (modifier_bits_o),
    .slots_o        (slots)
  );

  // Slots beyond the kept count read as empty.
  always_comb begin
    for (int j = 0; j < hkrb_pkg::SHOWN_SLOTS; j++) begin
      if (j < hkrb_pkg::KEY_SLOT_COUNT) begin
        shown[j] = slots[j];
      end else begin
        shown[j] = 8'h00;
      end
    end
  end

  assign key_slot_0_o = shown[0];
  assign key_slot_1_o = shown[1];
  assign key_slot_2_o = shown[2];
  assign key_slot_3_o = shown[3];
  assign key_slot_4_o = shown[4];
  assign key_slot_5_o = shown[5];

endmodule

// File: test/hid_keyboard_report_builder_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for hid_keyboard_report_builder_top: press, release,
// release-all and poll requests are checked against a keyboard report model
// kept in this file. Depends on hkrb_pkg for the request function codes.
module hid_keyboard_report_builder_top_tb;

  localparam int NUM_SLOTS       = 6;
  localparam int RANDOM_REQUESTS = 930;
  localparam int STALL_LIMIT     = 2000;
  localparam int TAIL_CYCLES     = 12;
  localparam int MAX_REPORTED    = 10;
  // Requests with these sequence numbers get no random idle gaps; a drain request still waits.
  localparam int BURST_FIRST     = 400;
  localparam int BURST_LAST      = 560;

  localparam logic [7:0] SHIFT_BIT = 8'h02;

  // ASCII to usage; bit 7 marks a character that is typed with shift held.
  localparam logic [7:0] ASCII_USAGE [128] = '{
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h2a,8'h2b,8'h28,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h29,8'h00,8'h00,8'h00,8'h00,
    8'h2c,8'h9e,8'hb4,8'ha0,8'ha1,8'ha2,8'ha4,8'h34,
    8'ha6,8'ha7,8'ha5,8'hae,8'h36,8'h2d,8'h37,8'h38,
    8'h27,8'h1e,8'h1f,8'h20,8'h21,8'h22,8'h23,8'h24,
    8'h25,8'h26,8'hb3,8'h33,8'hb6,8'h2e,8'hb7,8'hb8,
    8'h9f,8'h84,8'h85,8'h86,8'h87,8'h88,8'h89,8'h8a,
    8'h8b,8'h8c,8'h8d,8'h8e,8'h8f,8'h90,8'h91,8'h92,
    8'h93,8'h94,8'h95,8'h96,8'h97,8'h98,8'h99,8'h9a,
    8'h9b,8'h9c,8'h9d,8'h2f,8'h31,8'h30,8'ha3,8'had,
    8'h35,8'h04,8'h05,8'h06,8'h07,8'h08,8'h09,8'h0a,
    8'h0b,8'h0c,8'h0d,8'h0e,8'h0f,8'h10,8'h11,8'h12,
    8'h13,8'h14,8'h15,8'h16,8'h17,8'h18,8'h19,8'h1a,
    8'h1b,8'h1c,8'h1d,8'haf,8'hb1,8'hb0,8'hb5,8'h00
  };

  // One request as the sender sees it. When drain is set, the sender holds
  // the request back until every outstanding report has come back.
  typedef struct packed {
    logic [1:0] func;
    logic [7:0] code;
    logic       drain;
  } key_request_t;

  // One report as the block should return it.
  typedef struct packed {
    logic                      accepted;
    logic                      valid;
    logic [7:0]                mods;
    logic [NUM_SLOTS-1:0][7:0] slots;
  } key_report_t;

  logic       clk_i;
  logic       rst_ni;
  logic       start_i;
  logic       busy_o;
  logic [1:0] func_i;
  logic [7:0] key_code_i;
  logic       done_o;
  logic       accepted_o;
  logic       report_valid_o;
  logic [7:0] modifier_bits_o;
  logic [7:0] key_slot_0_o;
  logic [7:0] key_slot_1_o;
  logic [7:0] key_slot_2_o;
  logic [7:0] key_slot_3_o;
  logic [7:0] key_slot_4_o;
  logic [7:0] key_slot_5_o;

  // Model copy of the report held by the block.
  logic [7:0]                held_mods;
  logic [NUM_SLOTS-1:0][7:0] held_slots;
  logic                      held_dirty;

  key_request_t pending_q [$];
  key_report_t  report_expect_q [$];

  int n_issued;
  int n_taken;
  int quiet_cycles;
  int fail_count;

  hid_keyboard_report_builder_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .func_i         (func_i),
    .key_code_i     (key_code_i),
    .done_o         (done_o),
    .accepted_o     (accepted_o),
    .report_valid_o (report_valid_o),
    .modifier_bits_o(modifier_bits_o),
    .key_slot_0_o   (key_slot_0_o),
    .key_slot_1_o   (key_slot_1_o),
    .key_slot_2_o   (key_slot_2_o),
    .key_slot_3_o   (key_slot_3_o),
    .key_slot_4_o   (key_slot_4_o),
    .key_slot_5_o   (key_slot_5_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Decodes a non-modifier key code into {shift, usage}; a usage of zero
  // means that the code has no mapping.
  function automatic logic [8:0] decode_usage(input logic [7:0] code);
    logic [7:0] rom;
    if (code >= 8'hD7 && code <= 8'hDA) begin
      // Right, Left, Down, Up.
      return {1'b0, 8'h4F + (code - 8'hD7)};
    end else if (code >= 8'hB0 && code <= 8'hB3) begin
      // Enter, Escape, Backspace, Tab.
      return {1'b0, 8'h28 + (code - 8'hB0)};
    end else if (code == 8'hC1) begin
      return {1'b0, 8'h39};
    end else if (code >= 8'hC2 && code <= 8'hCD) begin
      return {1'b0, 8'h3A + (code - 8'hC2)};
    end else if (code >= 8'hD1 && code <= 8'hD6) begin
      return {1'b0, 8'h49 + (code - 8'hD1)};
    end else if (code < 8'h80) begin
      rom = ASCII_USAGE[code[6:0]];
      return {rom[7], 1'b0, rom[6:0]};
    end
    return 9'd0;
  endfunction

  // Applies one request to the model report and returns the report that
  // the block should hand back for it.
  function automatic key_report_t apply_key_request(input logic [1:0] func,
                                                    input logic [7:0] code);
    key_report_t rpt;
    logic [8:0]  dec;
    logic [7:0]  usage;
    int          hit;
    int          free_slot;
    rpt       = '0;
    dec       = decode_usage(code);
    usage     = dec[7:0];
    hit       = -1;
    free_slot = -1;
    // Walk downwards so that the lowest matching or empty slot wins.
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (held_slots[i] == usage) hit = i;
      if (held_slots[i] == 8'h00) free_slot = i;
    end
    case (func)
      hkrb_pkg::FUNC_PRESS, hkrb_pkg::FUNC_RELEASE: begin
        if (code >= 8'h80 && code <= 8'h87) begin
          if (func == hkrb_pkg::FUNC_PRESS) held_mods[code[2:0]] = 1'b1;
          else held_mods[code[2:0]] = 1'b0;
          held_dirty   = 1'b1;
          rpt.accepted = 1'b1;
        end else if (usage != 8'h00) begin
          // The shift bit moves even when the slot part fails.
          if (dec[8]) begin
            if (func == hkrb_pkg::FUNC_PRESS) held_mods = held_mods | SHIFT_BIT;
            else held_mods = held_mods & ~SHIFT_BIT;
          end
          if (func == hkrb_pkg::FUNC_PRESS) begin
            if (hit >= 0) begin
              rpt.accepted = 1'b1;
            end else if (free_slot >= 0) begin
              held_slots[free_slot] = usage;
              held_dirty            = 1'b1;
              rpt.accepted          = 1'b1;
            end
          end else if (hit >= 0) begin
            held_slots[hit] = 8'h00;
            held_dirty      = 1'b1;
            rpt.accepted    = 1'b1;
          end
        end
      end
      hkrb_pkg::FUNC_RELEASE_ALL: begin
        held_mods    = '0;
        held_slots   = '0;
        held_dirty   = 1'b1;
        rpt.accepted = 1'b1;
      end
      default: begin
        if (held_dirty) begin
          rpt.accepted = 1'b1;
          rpt.valid    = 1'b1;
          held_dirty   = 1'b0;
        end
      end
    endcase
    rpt.mods  = held_mods;
    rpt.slots = held_slots;
    return rpt;
  endfunction

  task automatic queue_request(input logic [1:0] func, input logic [7:0] code,
                               input logic drain);
    key_request_t req;
    req.func  = func;
    req.code  = code;
    req.drain = drain;
    pending_q.push_back(req);
  endtask

  task automatic note_mismatch(input string field, input int want, input int got);
    fail_count++;
    if (fail_count <= MAX_REPORTED)
      $display("%0t: mismatch on %s: expected 0x%0h, got 0x%0h", $realtime, field,
               want, got);
  endtask

  // Driver. Inputs change only on the falling edge. A request stays on the
  // bus until the monitor has seen it taken; once the bus is free the driver
  // either idles (putting noise on the request fields) or puts up the next
  // request from the queue. Each signal receives a single assignment per
  // edge, so start_i never dips between back-to-back requests.
  always @(negedge clk_i) begin : driver
    key_request_t nxt;
    logic         go;
    if (rst_ni && !(start_i && n_taken < n_issued)) begin
      go = 1'b0;
      if (pending_q.size() != 0) begin
        nxt = pending_q[0];
        if (nxt.drain && report_expect_q.size() != 0) go = 1'b0;
        else if (n_issued >= BURST_FIRST && n_issued <= BURST_LAST) go = 1'b1;
        else go = ($urandom_range(99) >= 27);
      end
      if (go) begin
        void'(pending_q.pop_front());
        start_i    <= 1'b1;
        func_i     <= nxt.func;
        key_code_i <= nxt.code;
        n_issued++;
      end else begin
        start_i    <= 1'b0;
        func_i     <= 2'($urandom_range(3));
        key_code_i <= 8'($urandom_range(255));
      end
    end
  end

  // Monitor. Everything is sampled on the rising edge, before the block's
  // registers move. A result in the same cycle as a newly taken request
  // belongs to an older request, so it is checked before the new request
  // is put through the model.
  always @(posedge clk_i) begin : monitor
    key_report_t               want;
    logic [NUM_SLOTS-1:0][7:0] seen_slots;
    logic                      taken;
    if (rst_ni) begin
      seen_slots = {key_slot_5_o, key_slot_4_o, key_slot_3_o,
                    key_slot_2_o, key_slot_1_o, key_slot_0_o};
      taken      = start_i && !busy_o;
      if (done_o) begin
        if (report_expect_q.size() == 0) begin
          note_mismatch("unexpected report", 0, 1);
        end else begin
          want = report_expect_q.pop_front();
          if (accepted_o !== want.accepted)
            note_mismatch("accepted", want.accepted, accepted_o);
          if (report_valid_o !== want.valid)
            note_mismatch("report_valid", want.valid, report_valid_o);
          if (modifier_bits_o !== want.mods)
            note_mismatch("modifier_bits", want.mods, modifier_bits_o);
          for (int i = 0; i < NUM_SLOTS; i++)
            if (seen_slots[i] !== want.slots[i])
              note_mismatch($sformatf("key_slot_%0d", i), want.slots[i], seen_slots[i]);
        end
      end
      if (taken) begin
        report_expect_q.push_back(apply_key_request(func_i, key_code_i));
        n_taken++;
      end
      // Watchdog: a run that neither takes a request nor returns a report
      // for this long has hung.
      if (taken || done_o) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout after %0d quiet cycles", STALL_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [7:0] held_codes [$];
    logic [7:0] code;
    int         pick;
    int         idx;
    logic       drain;
    rst_ni       = 1'b0;
    start_i      = 1'b0;
    func_i       = hkrb_pkg::FUNC_POLL;
    key_code_i   = 8'h00;
    held_mods    = '0;
    held_slots   = '0;
    held_dirty   = 1'b0;
    n_issued     = 0;
    n_taken      = 0;
    quiet_cycles = 0;
    fail_count   = 0;

    // Directed opening: a poll of a clean report, both ends of the modifier
    // range, unmapped codes, every non-ASCII key group, a full report, a
    // shifted character that finds no room, a repeated press, double polls,
    // a release of a key that is not down and release-all.
    queue_request(hkrb_pkg::FUNC_POLL, 8'h00, 1'b0);
    queue_request(hkrb_pkg::FUNC_PRESS, 8'h80, 1'b0);
    queue_request(hkrb_pkg::FUNC_PRESS, 8'h87, 1'b0);
    queue_request(hkrb_pkg::FUNC_RELEASE, 8'h87, 1'b0);
    queue_request(hkrb_pkg::FUNC_PRESS, 8'h00, 1'b0);
    queue_request(hkrb_pkg::FUNC_PRESS, 8'hFF, 1'b0);
    queue_request(hkrb_pkg::FUNC_PRESS, 8'h88, 1'b0);
    queue_request(hkrb_pkg::FUNC_PRESS, 8'hB0, 1'b0);
    queue_request(hkrb_pkg::FUNC_PRESS, 8'hB3, 1'b0);
    queue_request(hkrb_pkg::FUNC_PRESS, 8'hC1, 1'b0);
    queue_request(hkrb_pkg::FUNC_PRESS, 8'hCD, 1'b0);
    queue_request(hkrb_pkg::FUNC_PRESS, 8'hD7, 1'b0);
    queue_request(hkrb_pkg::FUNC_PRESS, 8'hDA, 1'b0);
    queue_request(hkrb_pkg::FUNC_PRESS, 8'h41, 1'b0);
    queue_request(hkrb_pkg::FUNC_PRESS, 8'hB0, 1'b0);
    // This poll waits until every earlier report has come back.
    queue_request(hkrb_pkg::FUNC_POLL, 8'hA5, 1'b1);
    queue_request(hkrb_pkg::FUNC_POLL, 8'h5A, 1'b0);
    queue_request(hkrb_pkg::FUNC_RELEASE, 8'h61, 1'b0);
    queue_request(hkrb_pkg::FUNC_RELEASE, 8'hCD, 1'b0);
    queue_request(hkrb_pkg::FUNC_PRESS, 8'h7F, 1'b0);
    queue_request(hkrb_pkg::FUNC_PRESS, 8'h21, 1'b0);
    queue_request(hkrb_pkg::FUNC_RELEASE, 8'h21, 1'b0);
    queue_request(hkrb_pkg::FUNC_PRESS, 8'hD1, 1'b0);
    queue_request(hkrb_pkg::FUNC_RELEASE_ALL, 8'hFF, 1'b0);
    queue_request(hkrb_pkg::FUNC_POLL, 8'h00, 1'b0);

    // Random part: mostly typing, that is presses of keys, most of them mapped, and the
    // release of keys still held, with polls and the odd release-all, plus
    // some fully random requests as noise. A few requests wait for the
    // block to drain completely.
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      pick  = $urandom_range(99);
      drain = (n % 150 == 75);
      if (pick < 38) begin
        case ($urandom_range(5))
          0: code = 8'h80 + 8'($urandom_range(7));
          1: code = 8'hB0 + 8'($urandom_range(3));
          2: code = 8'hC1 + 8'($urandom_range(12));
          3: code = 8'hD1 + 8'($urandom_range(9));
          default: code = 8'($urandom_range(8'h7F, 8'h08));
        endcase
        queue_request(hkrb_pkg::FUNC_PRESS, code, drain);
        held_codes.push_back(code);
      end else if (pick < 68 && held_codes.size() != 0) begin
        idx  = $urandom_range(held_codes.size() - 1);
        code = held_codes[idx];
        held_codes.delete(idx);
        queue_request(hkrb_pkg::FUNC_RELEASE, code, drain);
      end else if (pick < 80) begin
        queue_request(hkrb_pkg::FUNC_POLL, 8'($urandom_range(255)), drain);
      end else if (pick < 84) begin
        queue_request(hkrb_pkg::FUNC_RELEASE_ALL, 8'($urandom_range(255)), drain);
        held_codes.delete();
      end else begin
        queue_request(2'($urandom_range(3)), 8'($urandom_range(255)), drain);
      end
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Wait until every request has been taken and every report checked,
    // then keep watching for TAIL_CYCLES to catch any stray report.
    while (pending_q.size() != 0 || n_taken != n_issued || report_expect_q.size() != 0)
      @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (fail_count == 0 && report_expect_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
